### design/spa_pkg.sv
// Shared types, codes and defaults for the sparse polynomial adder.
package spa_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int COEFF_W       = 16;
  localparam int EXP_W         = 16;
  localparam int SUM_W         = COEFF_W + 1;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [COEFF_W-1:0] term_coeff;
    logic [EXP_W-1:0]          term_exponent;
  } in_beat_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_coeff;
    logic [EXP_W-1:0]        sum_exponent;
    logic                    last_term;
    logic                    empty_sum;
    logic                    overflow_seen;
  } out_beat_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic step;
    logic finish;
  } spa_cmd_t;

  typedef struct packed {
    logic out_free;
    logic run_last;
  } spa_status_t;

endpackage

### design/spa_ctrl.sv
// Controller state machine for the sparse polynomial adder.
module spa_ctrl
  import spa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [1:0]  opcode,
  output logic        in_stall,
  output spa_cmd_t    cmd,
  input  spa_status_t status
);

  typedef enum logic {
    S_IDLE,
    S_MERGE
  } state_t;

  state_t state;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd.load_a = accept && (opcode == OP_LOAD_A);
    cmd.load_b = accept && (opcode == OP_LOAD_B);
    cmd.step   = (state == S_MERGE) && status.out_free;
    cmd.finish = (state == S_MERGE) && status.out_free && status.run_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (opcode == OP_RUN)) begin
            state    <= S_MERGE;
            in_stall <= 1'b1;
          end
        end
        S_MERGE: begin
          if (cmd.finish) begin
            state    <= S_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

### design/spa_dp.sv
// Datapath of the sparse polynomial adder: term lists, merge logic and output register.
module spa_dp
  import spa_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  in_beat_t    in_beat,
  input  spa_cmd_t    cmd,
  output spa_status_t status,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_beat
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [COEFF_W-1:0] mem_a_c [DEPTH];
  logic [EXP_W-1:0]          mem_a_e [DEPTH];
  logic signed [COEFF_W-1:0] mem_b_c [DEPTH];
  logic [EXP_W-1:0]          mem_b_e [DEPTH];

  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  logic          dropped;
  logic [CW-1:0] ia;
  logic [CW-1:0] ib;
  logic [CW-1:0] ia_adv;
  logic [CW-1:0] ib_adv;
  logic [CW-1:0] ia_next;
  logic [CW-1:0] ib_next;

  logic signed [COEFF_W-1:0] head_a_c;
  logic [EXP_W-1:0]          head_a_e;
  logic signed [COEFF_W-1:0] head_b_c;
  logic [EXP_W-1:0]          head_b_e;

  logic                    a_ok;
  logic                    b_ok;
  logic                    both_empty;
  logic                    term_last;
  logic signed [SUM_W-1:0] term_c;
  logic [EXP_W-1:0]        term_e;

  // Pick the next term of the sum from the two list heads.
  always_comb begin
    a_ok       = ia < count_a;
    b_ok       = ib < count_b;
    both_empty = (count_a == '0) && (count_b == '0);
    ia_adv     = ia;
    ib_adv     = ib;
    term_c     = '0;
    term_e     = '0;
    if (a_ok && b_ok) begin
      if (head_a_e == head_b_e) begin
        term_c = SUM_W'(head_a_c) + SUM_W'(head_b_c);
        term_e = head_a_e;
        ia_adv = ia + CW'(1);
        ib_adv = ib + CW'(1);
      end else if (head_a_e > head_b_e) begin
        term_c = SUM_W'(head_a_c);
        term_e = head_a_e;
        ia_adv = ia + CW'(1);
      end else begin
        term_c = SUM_W'(head_b_c);
        term_e = head_b_e;
        ib_adv = ib + CW'(1);
      end
    end else if (a_ok) begin
      term_c = SUM_W'(head_a_c);
      term_e = head_a_e;
      ia_adv = ia + CW'(1);
    end else if (b_ok) begin
      term_c = SUM_W'(head_b_c);
      term_e = head_b_e;
      ib_adv = ib + CW'(1);
    end
    term_last = (ia_adv >= count_a) && (ib_adv >= count_b);

    if (cmd.finish) begin
      ia_next = '0;
      ib_next = '0;
    end else if (cmd.step) begin
      ia_next = ia_adv;
      ib_next = ib_adv;
    end else begin
      ia_next = ia;
      ib_next = ib;
    end

    status.out_free = !out_valid || !out_stall;
    status.run_last = both_empty || term_last;
  end

  // List storage with registered reads of the next heads.
  always_ff @(posedge clk) begin
    if (cmd.load_a && (count_a < CW'(DEPTH))) begin
      mem_a_c[count_a[IW-1:0]] <= in_beat.term_coeff;
      mem_a_e[count_a[IW-1:0]] <= in_beat.term_exponent;
    end
    if (cmd.load_b && (count_b < CW'(DEPTH))) begin
      mem_b_c[count_b[IW-1:0]] <= in_beat.term_coeff;
      mem_b_e[count_b[IW-1:0]] <= in_beat.term_exponent;
    end
    head_a_c <= mem_a_c[ia_next[IW-1:0]];
    head_a_e <= mem_a_e[ia_next[IW-1:0]];
    head_b_c <= mem_b_c[ib_next[IW-1:0]];
    head_b_e <= mem_b_e[ib_next[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a   <= '0;
      count_b   <= '0;
      dropped   <= 1'b0;
      ia        <= '0;
      ib        <= '0;
      out_valid <= 1'b0;
    end else begin
      ia <= ia_next;
      ib <= ib_next;
      if (cmd.finish) begin
        count_a <= '0;
        count_b <= '0;
        dropped <= 1'b0;
      end else begin
        if (cmd.load_a) begin
          if (count_a < CW'(DEPTH)) begin
            count_a <= count_a + CW'(1);
          end else begin
            dropped <= 1'b1;
          end
        end
        if (cmd.load_b) begin
          if (count_b < CW'(DEPTH)) begin
            count_b <= count_b + CW'(1);
          end else begin
            dropped <= 1'b1;
          end
        end
      end
      if (cmd.step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_beat.sum_coeff     <= both_empty ? '0 : term_c;
      out_beat.sum_exponent  <= both_empty ? '0 : term_e;
      out_beat.last_term     <= both_empty || term_last;
      out_beat.empty_sum     <= both_empty;
      out_beat.overflow_seen <= dropped;
    end
  end

`ifndef ASSERT_OFF
  a_count_a_range: assert property (@(posedge clk) disable iff (rst)
    count_a <= CW'(DEPTH)) else $error("list A count beyond depth");
  a_ia_range: assert property (@(posedge clk) disable iff (rst)
    ia <= count_a) else $error("list A read index beyond count");
  a_step_free: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (!out_valid || !out_stall)) else $error("step into a held output");
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (count_a == '0) && (count_b == '0) && (ia == '0) && (ib == '0))
    else $error("lists not cleared after run");
`endif

endmodule

### design/sparse_polynomial_add_top.sv
// An accepted run beat starts the merge; its first result beat is registered when the output
// register is free. Throughput: loads are taken one beat per cycle while no run is active;
// a run emits one result beat per cycle unless the output stalls, and stalls the input until
// its last result beat is registered. The pace of a run is set by the single read port of
// each list memory feeding the merge. Reset clears the list counts, the overflow flag and the
// controller; list contents are not cleared, since only entries below a count are ever used.
module sparse_polynomial_add_top
  import spa_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  // The controller decides what happens each cycle: it turns accepted load beats into
  // writes of list A or list B, and while a run is active it steps the merge whenever the
  // output register is empty or being emptied, finishing on the last term of the sum.
  spa_cmd_t    cmd;
  spa_status_t status;

  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (in_beat.opcode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // The datapath holds both term lists, the registered list heads, the merge comparison
  // and the output register that parts the result beat from the input side.
  spa_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

### sim/tb_sparse_polynomial_add_top.sv
// Self-checking testbench for the sparse polynomial adder: term loads, merge runs and checks.
`timescale 1ns / 100ps

module tb_sparse_polynomial_add_top;
  import spa_pkg::*;

  // The block is built with its default list depth, and the local copy of the
  // list state below is sized to match.
  localparam int DEPTH = DEPTH_DEFAULT;

  // The two-bit opcode field has one value the block has no use for. Such a
  // beat must be taken and then ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Least number of random beats (loads and runs) planned after the directed part.
  localparam int RANDOM_BEATS = 470;

  // After this many accepted input beats the receiver holds off for a long
  // stretch, so that a run backs up and the block stalls its input.
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 400;

  // Cycles allowed after the last expected result for stray output beats.
  localparam int TAIL_CYCLES = 20;

  // A generous bound on the whole run, well above the slowest correct one,
  // even with every beat a full run under the longest receiver hold-offs.
  localparam int CYCLE_LIMIT = 4000000;

  // Only the first few mismatches are printed in full.
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    in_beat_t    beat;
    int unsigned gap_after;
    bit          drain_first;
  } planned_beat_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  sparse_polynomial_add_top #(
    .DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Local copy of the block's state, used to work out the sum terms.
  // ---------------------------------------------------------------------
  logic [COEFF_W-1:0] a_coeff [DEPTH];
  logic [EXP_W-1:0]   a_exp   [DEPTH];
  logic [COEFF_W-1:0] b_coeff [DEPTH];
  logic [EXP_W-1:0]   b_exp   [DEPTH];
  int unsigned        len_a;
  int unsigned        len_b;
  logic               dropped;

  // Sum terms still owed by the block, oldest first.
  out_beat_t     expected_terms [$];
  // Input beats waiting to be offered, filled by the stimulus process.
  planned_beat_t load_plan [$];

  // Run statistics for the closing summary.
  int accepted_beats = 0;
  int runs_seen      = 0;
  int empty_runs     = 0;
  int dropped_loads  = 0;
  int equal_merges   = 0;
  int terms_checked  = 0;
  int fault_count    = 0;
  int cycle_count    = 0;

  // Applies one accepted input beat to the local state. A load appends to its
  // list unless the list is full, in which case it is dropped and flagged. A
  // run merges the two lists by exponent and queues one expected beat per sum
  // term, or a single beat marked empty when both lists hold nothing.
  task automatic predict_sum_terms(input in_beat_t beat);
    int unsigned ia;
    int unsigned ib;
    out_beat_t   term;
    ia = 0;
    ib = 0;
    if (beat.opcode == OP_LOAD_A || beat.opcode == OP_LOAD_B) begin
      if (beat.opcode == OP_LOAD_A && len_a < DEPTH) begin
        a_coeff[len_a] = beat.term_coeff;
        a_exp[len_a]   = beat.term_exponent;
        len_a++;
      end else if (beat.opcode == OP_LOAD_B && len_b < DEPTH) begin
        b_coeff[len_b] = beat.term_coeff;
        b_exp[len_b]   = beat.term_exponent;
        len_b++;
      end else begin
        dropped = 1'b1;
        dropped_loads++;
      end
    end else if (beat.opcode == OP_RUN) begin
      runs_seen++;
      if (len_a == 0 && len_b == 0) begin
        term               = '0;
        term.last_term     = 1'b1;
        term.empty_sum     = 1'b1;
        term.overflow_seen = dropped;
        expected_terms.push_back(term);
        empty_runs++;
      end
      while (ia < len_a || ib < len_b) begin
        term = '0;
        if (ia < len_a && ib < len_b && a_exp[ia] == b_exp[ib]) begin
          // Equal exponents: one term with the widened sum, zero sums kept.
          term.sum_coeff    = {a_coeff[ia][COEFF_W-1], a_coeff[ia]} +
                              {b_coeff[ib][COEFF_W-1], b_coeff[ib]};
          term.sum_exponent = a_exp[ia];
          ia++;
          ib++;
          equal_merges++;
        end else if (ia < len_a && (ib >= len_b || a_exp[ia] > b_exp[ib])) begin
          term.sum_coeff    = {a_coeff[ia][COEFF_W-1], a_coeff[ia]};
          term.sum_exponent = a_exp[ia];
          ia++;
        end else begin
          term.sum_coeff    = {b_coeff[ib][COEFF_W-1], b_coeff[ib]};
          term.sum_exponent = b_exp[ib];
          ib++;
        end
        term.last_term     = (ia >= len_a && ib >= len_b);
        term.overflow_seen = dropped;
        expected_terms.push_back(term);
      end
      len_a   = 0;
      len_b   = 0;
      dropped = 1'b0;
    end
    // The unused opcode leaves the state untouched.
  endtask

  // ---------------------------------------------------------------------
  // Stimulus planning.
  // ---------------------------------------------------------------------

  // When set, the beats being planned carry no gap, giving stretches of
  // back-to-back traffic.
  bit quiet_feed = 1'b0;

  // Idle lengths: mostly short, now and then long.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      return $urandom_range(1, 3);
    end else if (roll < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      return 16'h7fff;
    end else if (roll < 16) begin
      return 16'h8000;
    end else if (roll < 20) begin
      return '0;
    end
    return COEFF_W'($urandom());
  endfunction

  task automatic plan_beat(input logic [1:0] op, input logic [COEFF_W-1:0] coeff,
                           input logic [EXP_W-1:0] expo, input bit drain_first);
    planned_beat_t item;
    item.beat.opcode        = op;
    item.beat.term_coeff    = coeff;
    item.beat.term_exponent = expo;
    item.drain_first        = drain_first;
    if (quiet_feed || $urandom_range(0, 99) < 55) begin
      item.gap_after = 0;
    end else begin
      item.gap_after = idle_length();
    end
    load_plan.push_back(item);
  endtask

  // Plans one pair of polynomials and the run that adds them. Most pairs are
  // well formed: exponents in descending order, some shared between the lists
  // so that coefficients get summed. The rest are left unsorted and salted
  // with beats of the unused opcode. Loads to the two lists are interleaved at
  // random, and an occasional large pair overfills a list.
  task automatic plan_polynomial_pair(input bit drain_first, output int beats_planned);
    int unsigned      roll;
    int unsigned      n;
    int unsigned      span;
    int unsigned      exps [$];
    int unsigned      which;
    int unsigned      fill_mode;
    bit               broken;
    bit               first;
    logic [COEFF_W-1:0] qa_c [$];
    logic [EXP_W-1:0]   qa_e [$];
    logic [COEFF_W-1:0] qb_c [$];
    logic [EXP_W-1:0]   qb_e [$];
    beats_planned = 0;
    first         = drain_first;
    quiet_feed    = ($urandom_range(0, 4) == 0);
    broken        = ($urandom_range(0, 99) < 15);
    fill_mode     = 3;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      n = $urandom_range(1, 6);
    end else if (roll < 88) begin
      n = $urandom_range(7, 14);
    end else if (roll < 96) begin
      n         = $urandom_range(17, 22);
      fill_mode = $urandom_range(0, 2);
    end else begin
      n = 0;
    end
    // A narrow exponent span makes ties between the lists likely.
    roll = $urandom_range(0, 99);
    span = (roll < 35) ? 15 : 65535;
    for (int i = 0; i < n; i++) begin
      exps.push_back($urandom_range(0, span));
    end
    if (!broken) begin
      exps.rsort();
    end
    foreach (exps[i]) begin
      which = (fill_mode == 3) ? $urandom_range(0, 2) : fill_mode;
      if (which != 1) begin
        qa_c.push_back(pick_coeff());
        qa_e.push_back(EXP_W'(exps[i]));
      end
      if (which != 0) begin
        qb_c.push_back(pick_coeff());
        qb_e.push_back(EXP_W'(exps[i]));
      end
    end
    while (qa_e.size() != 0 || qb_e.size() != 0) begin
      if (broken && $urandom_range(0, 5) == 0) begin
        plan_beat(OP_UNUSED, COEFF_W'($urandom()), EXP_W'($urandom()), first);
        first = 1'b0;
      end
      if (qb_e.size() == 0 || (qa_e.size() != 0 && $urandom_range(0, 1) == 0)) begin
        plan_beat(OP_LOAD_A, qa_c.pop_front(), qa_e.pop_front(), first);
      end else begin
        plan_beat(OP_LOAD_B, qb_c.pop_front(), qb_e.pop_front(), first);
      end
      first = 1'b0;
      beats_planned++;
    end
    plan_beat(OP_RUN, COEFF_W'($urandom()), EXP_W'($urandom()), first);
    beats_planned++;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------
  initial begin
    int planned;
    int pair_beats;
    int pair_index;
    bit drain;
    len_a   = 0;
    len_b   = 0;
    dropped = 1'b0;

    // Directed part. A run with both lists empty comes first.
    plan_beat(OP_RUN, 16'hffff, 16'hffff, 1'b0);
    // Extreme coefficients and exponents, with sums at the low end of the widened range and just
    // below its high end, and one sum of zero that must still be emitted.
    plan_beat(OP_LOAD_A, 16'h7fff, 16'hffff, 1'b0);
    plan_beat(OP_LOAD_A, 16'h8000, 16'd100, 1'b0);
    plan_beat(OP_LOAD_A, 16'h0001, 16'h0000, 1'b0);
    plan_beat(OP_LOAD_B, 16'h7fff, 16'hffff, 1'b0);
    plan_beat(OP_LOAD_B, 16'h8000, 16'd100, 1'b0);
    plan_beat(OP_LOAD_B, 16'hffff, 16'h0000, 1'b0);
    plan_beat(OP_RUN, 16'h0000, 16'h0000, 1'b0);
    // List A overfilled with terms in ascending order while list B stays
    // empty: one load is dropped, the whole list drains as leftover terms and
    // every result reports the overflow.
    for (int i = 0; i <= DEPTH; i++) begin
      plan_beat(OP_LOAD_A, pick_coeff(), 16'(i * 1000), 1'b0);
    end
    plan_beat(OP_RUN, 16'h5a5a, 16'ha5a5, 1'b0);
    // A beat with the unused opcode and every payload bit set is ignored.
    plan_beat(OP_UNUSED, 16'hffff, 16'hffff, 1'b0);

    // Random part: pairs of polynomials, each followed by its run. Every so
    // often the sender waits for all owed results before the next pair, but
    // not around the receiver's long hold-off, where it keeps offering beats.
    planned    = 0;
    pair_index = 0;
    while (planned < RANDOM_BEATS) begin
      drain = (pair_index % 12 == 11) &&
              !(load_plan.size() > HOLD_AT - 30 && load_plan.size() < HOLD_AT + 70);
      plan_polynomial_pair(drain, pair_beats);
      planned += pair_beats;
      pair_index++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (load_plan.size() != 0 || in_valid) @(posedge clk);
    while (expected_terms.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d input beats in %0d runs (%0d with both lists empty), %0d loads dropped.",
             accepted_beats, runs_seen, empty_runs, dropped_loads);
    $display("Checked %0d sum terms, %0d of them from equal exponents; %0d faults.",
             terms_checked, equal_merges, fault_count);
    if (fault_count == 0 && expected_terms.size() == 0) begin
      $display("sparse_polynomial_add_top verification clean");
    end else begin
      $display("sparse_polynomial_add_top verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: offers planned beats, holding each one steady while stalled.
  // A beat marked to drain waits until every owed result has come back.
  // ---------------------------------------------------------------------
  int unsigned   gap_left = 0;
  planned_beat_t next_beat;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_beat  <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_sum_terms(in_beat);
        accepted_beats++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (load_plan.size() != 0 &&
                     !(load_plan[0].drain_first && expected_terms.size() != 0)) begin
          next_beat = load_plan.pop_front();
          in_valid  <= 1'b1;
          in_beat   <= next_beat.beat;
          gap_left  <= next_beat.gap_after;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and receiver: compares each accepted result beat with the oldest
  // expectation, and drives the output stall. The stall alternates between
  // calm phases and phases of random hold-offs, with one long hold-off once
  // enough input has gone in.
  // ---------------------------------------------------------------------
  int unsigned stall_left   = 0;
  int unsigned phase_left   = 0;
  bit          phase_calm   = 1'b0;
  bit          hold_started = 1'b0;
  out_beat_t   owed_term;

  always @(posedge clk) begin
    if (rst) begin
      out_stall    <= 1'b0;
      stall_left   <= 0;
      phase_left   <= 0;
      phase_calm   <= 1'b0;
      hold_started <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        terms_checked++;
        if (expected_terms.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected sum term: coeff %0d exponent %0d last %0b empty %0b ovf %0b",
                     $realtime, out_beat.sum_coeff, out_beat.sum_exponent,
                     out_beat.last_term, out_beat.empty_sum, out_beat.overflow_seen);
          end
        end else begin
          owed_term = expected_terms.pop_front();
          if (out_beat.sum_coeff !== owed_term.sum_coeff ||
              out_beat.sum_exponent !== owed_term.sum_exponent ||
              out_beat.last_term !== owed_term.last_term ||
              out_beat.empty_sum !== owed_term.empty_sum ||
              out_beat.overflow_seen !== owed_term.overflow_seen) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
              $display("%0t: sum term mismatch", $realtime);
              $display("  expected coeff %0d exponent %0d last %0b empty %0b ovf %0b",
                       owed_term.sum_coeff, owed_term.sum_exponent, owed_term.last_term,
                       owed_term.empty_sum, owed_term.overflow_seen);
              $display("  actual   coeff %0d exponent %0d last %0b empty %0b ovf %0b",
                       out_beat.sum_coeff, out_beat.sum_exponent, out_beat.last_term,
                       out_beat.empty_sum, out_beat.overflow_seen);
            end
          end
        end
      end

      if (phase_left == 0) begin
        phase_left <= $urandom_range(100, 400);
        phase_calm <= ($urandom_range(0, 3) == 0);
      end else begin
        phase_left <= phase_left - 1;
      end

      if (!hold_started && accepted_beats >= HOLD_AT) begin
        hold_started <= 1'b1;
        out_stall    <= 1'b1;
        stall_left   <= HOLD_CYCLES - 1;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (phase_calm || $urandom_range(0, 99) < 60) begin
        out_stall <= 1'b0;
      end else begin
        out_stall  <= 1'b1;
        stall_left <= idle_length() - 1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d sum terms still owed.",
               cycle_count, expected_terms.size());
      $display("sparse_polynomial_add_top verification failed");
      $finish;
    end
  end

endmodule

### filelist.f
design/spa_pkg.sv
design/spa_ctrl.sv
design/spa_dp.sv
design/sparse_polynomial_add_top.sv
sim/tb_sparse_polynomial_add_top.sv
